/* hdl/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// bfa_pkg
// Types, constants and codes shared by the frame allocator modules.
// ----------------------------------------------------------------------------
package bfa_pkg;

   localparam int PAGE_SHIFT = 12;
   localparam int MAX_FRAMES = 262144;

   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 32;
   localparam int FRAME_W  = 19;
   localparam int BYTES_W  = 16;
   localparam int WORD_W   = 32;
   localparam int BIT_W    = 5;
   localparam int WORDS    = (MAX_FRAMES + WORD_W - 1) / WORD_W;
   localparam int WADDR_W  = $clog2(WORDS);
   localparam int NWORDS_W = $clog2(WORDS + 1);
   localparam int FLIP_W   = BIT_W + 1;
   localparam int EXT_W    = ADDR_W + 2;

   localparam logic [2:0] OP_INIT    = 3'd0;
   localparam logic [2:0] OP_ALLOC   = 3'd1;
   localparam logic [2:0] OP_FREE    = 3'd2;
   localparam logic [2:0] OP_MARK    = 3'd3;
   localparam logic [2:0] OP_RESERVE = 3'd4;

   localparam logic [2:0] ST_DONE      = 3'd0;
   localparam logic [2:0] ST_NOT_READY = 3'd1;
   localparam logic [2:0] ST_NO_FREE   = 3'd2;
   localparam logic [2:0] ST_UNALIGNED = 3'd3;
   localparam logic [2:0] ST_RANGE     = 3'd4;
   localparam logic [2:0] ST_DOUBLE    = 3'd5;
   localparam logic [2:0] ST_IGNORED   = 3'd6;

   typedef struct packed {
      logic [2:0]        op;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  length;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  frame_address;
      logic [2:0]         status;
      logic [FRAME_W-1:0] frame_count;
      logic [FRAME_W-1:0] busy_count;
      logic [FRAME_W-1:0] spare_count;
      logic [BYTES_W-1:0] map_bytes;
   } rsp_type;

   typedef struct packed {
      logic [WORD_W-1:0] new_word;
      logic [FLIP_W-1:0] flips;
      logic              has_zero;
      logic [BIT_W-1:0]  zero_idx;
   } word_res_type;

endpackage

/* hdl/bfa_ram.sv */
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/bfa_word_unit.sv */
// ----------------------------------------------------------------------------
// bfa_word_unit
// Per-word bit work: range mask, set/clear, flip count, lowest free bit.
// ----------------------------------------------------------------------------
module bfa_word_unit (
   input  logic [bfa_pkg::WORD_W-1:0] word,
   input  logic [bfa_pkg::BIT_W-1:0]  lo,
   input  logic [bfa_pkg::BIT_W-1:0]  hi,
   input  logic                       set_mode,
   output bfa_pkg::word_res_type      res
);
   import bfa_pkg::*;

   logic [WORD_W-1:0] mask;
   logic [WORD_W-1:0] flipped;
   logic [FLIP_W-1:0] cnt;
   logic [BIT_W-1:0]  idx;

   always_comb begin
      mask    = ({WORD_W{1'b1}} << lo) & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi));
      flipped = set_mode ? (mask & ~word) : (mask & word);
      cnt = '0;
      for (int i = 0; i < WORD_W; i++) begin
         cnt = cnt + FLIP_W'(flipped[i]);
      end
      // lowest clear bit wins
      idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!word[i]) begin
            idx = BIT_W'(i);
         end
      end
      res.new_word = set_mode ? (word | mask) : (word & ~mask);
      res.flips    = cnt;
      res.has_zero = (word != {WORD_W{1'b1}});
      res.zero_idx = idx;
   end

endmodule

/* hdl/bitmap_frame_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// Page-frame allocator, one bit per frame held in a word RAM (1 = used).
// ----------------------------------------------------------------------------
//   channel  ports         direction  content
//   req      req_*         in         op, address, length
//   rsp      rsp_*         out        frame address, status, statistics
//   csr      csr_*         in         memory top in bytes
//
// One beat at a time. Decode leads to the result load; region ops first clip
// the bounds in between. Every bitmap word visited takes a RAM read, then
// modify and write back; alloc visits words until a free bit or the last word,
// region ops each word touched, free one. Init writes ceil(total/32) words,
// one a cycle. Reset is synchronous; no RAM clearing pass, init fills it.
// A new beat is taken while a result still waits in the output register.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  bfa_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bfa_pkg::rsp_type          rsp_data,
   input  logic                      csr_wr_en,
   input  logic [bfa_pkg::ADDR_W-1:0] csr_wr_data
);
   import bfa_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_DEC   = 7'b0000010,
      S_PREP  = 7'b0000100,
      S_RD    = 7'b0001000,
      S_MOD   = 7'b0010000,
      S_SWEEP = 7'b0100000,
      S_FIN   = 7'b1000000
   } state_type;

   localparam logic [EXT_W-1:0] PAGE_M1 = EXT_W'((64'd1 << PAGE_SHIFT) - 64'd1);

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  mtop_ff;
   logic [FRAME_W-1:0] total_ff, total_in;
   logic [FRAME_W-1:0] used_ff, used_in;
   logic               ready_ff, ready_in;
   req_type            req_ff;
   logic [EXT_W-1:0]   end_ff, end_in;
   logic [FRAME_W-1:0] fs_ff, fs_in;
   logic [FRAME_W-1:0] fl_ff, fl_in;
   logic [WADDR_W-1:0] ptr_ff, ptr_in;
   logic [WADDR_W-1:0] last_ff, last_in;
   logic [2:0]         status_ff, status_in;
   logic [ADDR_W-1:0]  faddr_ff, faddr_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic               ram_we;
   logic [WORD_W-1:0]  ram_wdata;
   logic               ram_re;
   logic [WORD_W-1:0]  ram_rdata;
   word_res_type       wres;
   logic [BIT_W-1:0]   lo, hi;
   logic               set_mode;

   logic [NWORDS_W-1:0] nwords;
   logic [WADDR_W-1:0]  nw_last;
   logic                is_ready;
   logic                out_free;
   logic [ADDR_W-1:0]   pages;
   logic [EXT_W-1:0]    top, sum_end;
   logic [EXT_W-1:0]    s_ext, e_ext;
   logic [FRAME_W-1:0]  s_fr, e_fr, fr;
   logic                reserve;

   assign nwords   = NWORDS_W'((EXT_W'(total_ff) + EXT_W'(WORD_W - 1)) >> BIT_W);
   assign nw_last  = WADDR_W'(nwords - NWORDS_W'(1));
   assign is_ready = ready_ff && (total_ff != '0);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign reserve  = (req_ff.op == OP_RESERVE);
   assign pages    = mtop_ff >> PAGE_SHIFT;
   assign top      = EXT_W'(total_ff) << PAGE_SHIFT;
   assign sum_end  = EXT_W'(req_ff.address) + EXT_W'(req_ff.length);
   assign fr       = FRAME_W'(req_ff.address >> PAGE_SHIFT);

   assign req_ready = state_ff == S_IDLE;

   // range ends of the current word
   assign lo = (ptr_ff == WADDR_W'(fs_ff >> BIT_W)) ? fs_ff[BIT_W-1:0] : '0;
   assign hi = (ptr_ff == last_ff) ? fl_ff[BIT_W-1:0] : {BIT_W{1'b1}};
   assign set_mode = (req_ff.op != OP_MARK) && (req_ff.op != OP_FREE);

   bfa_word_unit u_word (
      .word     (ram_rdata),
      .lo       (lo),
      .hi       (hi),
      .set_mode (set_mode),
      .res      (wres)
   );

   bfa_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_bitmap (
      .clock (clock),
      .we    (ram_we),
      .waddr (ptr_ff),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ptr_ff),
      .rdata (ram_rdata)
   );

   always_comb begin
      s_ext = reserve ? (EXT_W'(req_ff.address) & ~PAGE_M1)
                      : ((EXT_W'(req_ff.address) + PAGE_M1) & ~PAGE_M1);
      e_ext = reserve ? ((end_ff + PAGE_M1) & ~PAGE_M1) : (end_ff & ~PAGE_M1);
      s_fr  = FRAME_W'(s_ext >> PAGE_SHIFT);
      e_fr  = FRAME_W'(e_ext >> PAGE_SHIFT);
   end

   always_comb begin
      state_in  = state_ff;
      total_in  = total_ff;
      used_in   = used_ff;
      ready_in  = ready_ff;
      end_in    = end_ff;
      fs_in     = fs_ff;
      fl_in     = fl_ff;
      ptr_in    = ptr_ff;
      last_in   = last_ff;
      status_in = status_ff;
      faddr_in  = faddr_ff;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_wdata = wres.new_word;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in  = S_DEC;
               status_in = ST_DONE;
               faddr_in  = '0;
            end
         end
         S_DEC: begin
            state_in = S_FIN;
            ptr_in   = '0;
            if (req_ff.op == OP_INIT) begin
               total_in = (pages > ADDR_W'(MAX_FRAMES)) ? FRAME_W'(MAX_FRAMES)
                                                        : FRAME_W'(pages);
               used_in  = total_in;
               ready_in = 1'b1;
               state_in = S_SWEEP;
            end else if (req_ff.op > OP_RESERVE) begin
               status_in = ST_IGNORED;
            end else if (!is_ready) begin
               status_in = ST_NOT_READY;
            end else if (req_ff.op == OP_ALLOC) begin
               fs_in    = '0;
               fl_in    = '0;
               last_in  = nw_last;
               state_in = S_RD;
            end else if (req_ff.op == OP_FREE) begin
               if (req_ff.address[PAGE_SHIFT-1:0] != '0) begin
                  status_in = ST_UNALIGNED;
               end else if ((req_ff.address >> PAGE_SHIFT) >= ADDR_W'(total_ff)) begin
                  status_in = ST_RANGE;
               end else begin
                  fs_in    = fr;
                  fl_in    = fr;
                  ptr_in   = WADDR_W'(fr >> BIT_W);
                  last_in  = WADDR_W'(fr >> BIT_W);
                  state_in = S_RD;
               end
            end else if (req_ff.length == '0 || EXT_W'(req_ff.address) >= top) begin
               status_in = ST_IGNORED;
            end else begin
               end_in   = (sum_end > top) ? top : sum_end;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            if (e_fr <= s_fr) begin
               status_in = ST_IGNORED;
               state_in  = S_FIN;
            end else begin
               fs_in    = s_fr;
               fl_in    = e_fr - FRAME_W'(1);
               ptr_in   = WADDR_W'(s_fr >> BIT_W);
               last_in  = WADDR_W'((e_fr - FRAME_W'(1)) >> BIT_W);
               state_in = S_RD;
            end
         end
         S_RD: begin
            ram_re   = 1'b1;
            state_in = S_MOD;
         end
         S_MOD: begin
            if (req_ff.op == OP_ALLOC) begin
               if (wres.has_zero) begin
                  ram_we    = 1'b1;
                  ram_wdata = ram_rdata | (WORD_W'(1) << wres.zero_idx);
                  used_in   = used_ff + FRAME_W'(1);
                  faddr_in  = ADDR_W'({ptr_ff, wres.zero_idx}) << PAGE_SHIFT;
                  state_in  = S_FIN;
               end else if (ptr_ff == last_ff) begin
                  status_in = ST_NO_FREE;
                  state_in  = S_FIN;
               end else begin
                  ptr_in   = ptr_ff + WADDR_W'(1);
                  state_in = S_RD;
               end
            end else if (req_ff.op == OP_FREE && wres.flips == '0) begin
               status_in = ST_DOUBLE;
               state_in  = S_FIN;
            end else begin
               ram_we  = 1'b1;
               used_in = set_mode ? used_ff + FRAME_W'(wres.flips)
                                  : used_ff - FRAME_W'(wres.flips);
               if (ptr_ff == last_ff) begin
                  state_in = S_FIN;
               end else begin
                  ptr_in   = ptr_ff + WADDR_W'(1);
                  state_in = S_RD;
               end
            end
         end
         S_SWEEP: begin
            if (nwords == '0) begin
               state_in = S_FIN;
            end else begin
               ram_we    = 1'b1;
               ram_wdata = {WORD_W{1'b1}};
               if (ptr_ff == nw_last) begin
                  state_in = S_FIN;
               end else begin
                  ptr_in = ptr_ff + WADDR_W'(1);
               end
            end
         end
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mtop_ff      <= '0;
         total_ff     <= '0;
         used_ff      <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         used_ff  <= used_in;
         ready_ff <= ready_in;
         if (csr_wr_en) begin
            mtop_ff <= csr_wr_data;
         end
         if (state_ff == S_FIN && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         req_ff <= req_data;
      end
      end_ff    <= end_in;
      fs_ff     <= fs_in;
      fl_ff     <= fl_in;
      ptr_ff    <= ptr_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      faddr_ff  <= faddr_in;
      if (state_ff == S_FIN && out_free) begin
         rsp_ff.frame_address <= faddr_ff;
         rsp_ff.status        <= status_ff;
         rsp_ff.frame_count   <= total_ff;
         rsp_ff.busy_count    <= used_ff;
         rsp_ff.spare_count   <= (total_ff >= used_ff) ? total_ff - used_ff : '0;
         rsp_ff.map_bytes     <= BYTES_W'({nwords, 2'b00});
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_used_le_total: assert property (@(posedge clock) disable iff (reset)
      used_ff <= total_ff)
      else $error("used count above frame total");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_MOD || state_ff == S_SWEEP))
      else $error("bitmap write outside modify or sweep");

   a_read_then_mod: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RD |=> state_ff == S_MOD)
      else $error("read not followed by modify");

endmodule
